FILE: rtl/gcu_pkg.sv
package gcu_pkg;

  localparam int unsigned IDX_W = 5;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned COL_W = 2;
  localparam int unsigned DEG_W = 7;

  localparam logic [DEG_W-1:0] DEG_MAX = 7'd127;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  typedef struct packed {
    logic             add;
    logic             clr;
    logic [IDX_W-1:0] node_a;
    logic [IDX_W-1:0] node_b;
  } store_cmd_t;

endpackage

FILE: rtl/gcu_if.sv
interface gcu_in_if;
  logic                        valid;
  logic                        ready;
  logic [gcu_pkg::OP_W-1:0]    operation;
  logic [gcu_pkg::IDX_W-1:0]   node_a;
  logic [gcu_pkg::IDX_W-1:0]   node_b;

  modport source (output valid, operation, node_a, node_b, input ready);
  modport sink   (input valid, operation, node_a, node_b, output ready);
endinterface

interface gcu_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcu_pkg::IDX_W-1:0]   node_index;
  logic                        node_valid;
  logic [gcu_pkg::COL_W-1:0]   colour;
  logic                        painted;
  logic                        success;
  logic                        last;

  modport source (output valid, node_index, node_valid, colour, painted, success, last,
                  input ready);
  modport sink   (input valid, node_index, node_valid, colour, painted, success, last,
                  output ready);
endinterface

FILE: rtl/gcu_ram.sv
module gcu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/gcu_store.sv
module gcu_store #(
  parameter int unsigned NODES = 32,
  localparam int unsigned NodeW = $clog2(NODES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gcu_pkg::store_cmd_t             cmd_i,
  input  logic [NodeW-1:0]                row_sel_i,
  output logic [NODES-1:0]                row_o,
  input  logic [NodeW-1:0]                deg_sel_i,
  output logic [gcu_pkg::DEG_W-1:0]       deg_o
);

  logic [NODES-1:0]          adj_q [NODES];
  logic [gcu_pkg::DEG_W-1:0] deg_q [NODES];
  logic [gcu_pkg::DEG_W-1:0] deg_d [NODES];
  logic [NodeW-1:0]          a_idx;
  logic [NodeW-1:0]          b_idx;
  logic                      edge_ok;

  assign a_idx   = NodeW'(cmd_i.node_a);
  assign b_idx   = NodeW'(cmd_i.node_b);
  assign edge_ok = (32'(cmd_i.node_a) < NODES) && (32'(cmd_i.node_b) < NODES);

  // Each end adds one; a self-loop hits the same counter twice.
  always_comb begin
    logic [1:0]             inc;
    logic [gcu_pkg::DEG_W:0] sum;
    for (int i = 0; i < NODES; i++) begin
      inc = 2'(NodeW'(i) == a_idx) + 2'(NodeW'(i) == b_idx);
      sum = {1'b0, deg_q[i]} + (gcu_pkg::DEG_W + 1)'(inc);
      deg_d[i] = (sum > {1'b0, gcu_pkg::DEG_MAX}) ? gcu_pkg::DEG_MAX
                                                 : sum[gcu_pkg::DEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        adj_q[i] <= '0;
        deg_q[i] <= '0;
      end
    end else if (cmd_i.clr) begin
      for (int i = 0; i < NODES; i++) begin
        adj_q[i] <= '0;
        deg_q[i] <= '0;
      end
    end else if (cmd_i.add && edge_ok) begin
      adj_q[a_idx][b_idx] <= 1'b1;
      adj_q[b_idx][a_idx] <= 1'b1;
      for (int i = 0; i < NODES; i++) begin
        deg_q[i] <= deg_d[i];
      end
    end
  end

  assign row_o = adj_q[row_sel_i];
  assign deg_o = deg_q[deg_sel_i];

endmodule

FILE: rtl/greedy_graph_coloring_unit.sv
// Greedy graph coloring unit.
// Input channel in_i carries one word per command: add edge (node_a, node_b),
// run coloring, or clear graph. Add edge and clear leave the unit in S_IDLE,
// so in_i.ready stays high; operation code 3 is dropped.
// A run is sequenced through one compare path and two small RAMs:
//   ordering: one scan of all NODES degree counters per ordered node plus one
//     final scan, count = nodes with edges;
//   coloring: COLOURS passes over the count ordered nodes (visit RAM read,
//     then test against the pass mask);
//   report: states S_RRD, S_RNI and S_REM per node, S_REM waiting while out_o
//     is not taking words, then S_RRD to return to idle.
// The run emits one word per ordered node in visit order on out_o, with last
// on the final one; an empty graph gives a single word with node_valid low.
// in_i.ready stays low for the whole run and rises once the state is back in
// S_IDLE after the last word is loaded into the output register. That register
// holds its word while out_o.ready is low and the sequencer waits for it;
// nothing is dropped. Reset clears the adjacency matrix, degree counts and
// painted flags at once; no clearing pass is needed.
module greedy_graph_coloring_unit #(
  parameter int unsigned NODES   = 32,
  parameter int unsigned COLOURS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcu_in_if.sink      in_i,
  gcu_out_if.source   out_o
);

  localparam int unsigned NodeW = $clog2(NODES);
  localparam int unsigned CntW  = $clog2(NODES + 1);
  localparam int unsigned ClrW  = (COLOURS > 1) ? $clog2(COLOURS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SORT  = 8'b0000_0010,
    S_CRD   = 8'b0000_0100,
    S_CEV   = 8'b0000_1000,
    S_RRD   = 8'b0001_0000,
    S_RNI   = 8'b0010_0000,
    S_REM   = 8'b0100_0000,
    S_EMPTY = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [CntW-1:0]             k_q, k_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [NodeW-1:0]            scan_q, scan_d;
  logic [gcu_pkg::DEG_W-1:0]   best_deg_q, best_deg_d;
  logic [NodeW-1:0]            best_idx_q, best_idx_d;
  logic                        found_q, found_d;
  logic [ClrW-1:0]             pass_q, pass_d;
  logic [NODES-1:0]            mask_q, mask_d;
  logic [NODES-1:0]            painted_q, painted_d;
  logic [NODES-1:0]            ordered_q, ordered_d;
  logic                        success_q, success_d;

  logic                        out_valid_q, out_valid_d;
  logic [gcu_pkg::IDX_W-1:0]   out_idx_q;
  logic                        out_nv_q;
  logic [gcu_pkg::COL_W-1:0]   out_col_q;
  logic                        out_pnt_q;
  logic                        out_succ_q;
  logic                        out_last_q;
  logic                        out_load;
  logic                        out_empty;
  logic                        out_free;

  gcu_pkg::store_cmd_t         cmd;
  logic [NODES-1:0]            adj_row;
  logic [gcu_pkg::DEG_W-1:0]   deg_scan;

  logic                        ord_we;
  logic [NodeW-1:0]            ord_waddr;
  logic [NodeW-1:0]            ord_wdata;
  logic [NodeW-1:0]            ord_rdata;
  logic                        col_we;
  logic [ClrW-1:0]             col_rdata;

  logic                        cand;
  logic                        scan_end;
  logic                        in_fire;
  logic                        node_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    cmd        = '0;
    cmd.node_a = in_i.node_a;
    cmd.node_b = in_i.node_b;
    cmd.add    = in_fire && (in_i.operation == gcu_pkg::OP_ADD);
    cmd.clr    = in_fire && (in_i.operation == gcu_pkg::OP_CLR);
  end

  gcu_store #(
    .NODES (NODES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .row_sel_i (ord_rdata),
    .row_o     (adj_row),
    .deg_sel_i (scan_q),
    .deg_o     (deg_scan)
  );

  gcu_ram #(
    .WIDTH (NodeW),
    .DEPTH (NODES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (k_q[NodeW-1:0]),
    .rdata_o (ord_rdata)
  );

  gcu_ram #(
    .WIDTH (ClrW),
    .DEPTH (NODES)
  ) u_colour_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (ord_rdata),
    .wdata_i (pass_q),
    .raddr_i (ord_rdata),
    .rdata_o (col_rdata)
  );

  // Strict compare while scanning upward keeps the lower index on a tie.
  assign cand      = !ordered_q[scan_q] && (deg_scan > best_deg_q);
  assign scan_end  = (scan_q == NodeW'(NODES - 1));
  assign node_free = !painted_q[ord_rdata] && ((adj_row & mask_q) == '0);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    count_d    = count_q;
    scan_d     = scan_q;
    best_deg_d = best_deg_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    pass_d     = pass_q;
    mask_d     = mask_q;
    painted_d  = painted_q;
    ordered_d  = ordered_q;
    success_d  = success_q;
    ord_we     = 1'b0;
    ord_waddr  = count_q[NodeW-1:0];
    ord_wdata  = cand ? scan_q : best_idx_q;
    col_we     = 1'b0;
    out_load   = 1'b0;
    out_empty  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.operation)
            gcu_pkg::OP_RUN: begin
              count_d    = '0;
              scan_d     = '0;
              best_deg_d = '0;
              found_d    = 1'b0;
              ordered_d  = '0;
              painted_d  = '0;
              state_d    = S_SORT;
            end
            gcu_pkg::OP_CLR: begin
              ordered_d = '0;
              painted_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        if (cand) begin
          best_deg_d = deg_scan;
          best_idx_d = scan_q;
          found_d    = 1'b1;
        end
        if (scan_end) begin
          scan_d     = '0;
          best_deg_d = '0;
          found_d    = 1'b0;
          if (found_q || cand) begin
            ord_we               = 1'b1;
            ordered_d[ord_wdata] = 1'b1;
            count_d              = count_q + CntW'(1);
          end else if (count_q == '0) begin
            state_d = S_EMPTY;
          end else begin
            k_d     = '0;
            pass_d  = '0;
            mask_d  = '0;
            state_d = S_CRD;
          end
        end else begin
          scan_d = scan_q + NodeW'(1);
        end
      end
      S_CRD: begin
        if (k_q == count_q) begin
          k_d    = '0;
          mask_d = '0;
          pass_d = pass_q + ClrW'(1);
          if (pass_q == ClrW'(COLOURS - 1)) begin
            success_d = (painted_q == ordered_q);
            state_d   = S_RRD;
          end
        end else begin
          state_d = S_CEV;
        end
      end
      S_CEV: begin
        if (node_free) begin
          col_we               = 1'b1;
          painted_d[ord_rdata] = 1'b1;
          mask_d[ord_rdata]    = 1'b1;
        end
        k_d     = k_q + CntW'(1);
        state_d = S_CRD;
      end
      S_RRD: begin
        state_d = (k_q == count_q) ? S_IDLE : S_RNI;
      end
      S_RNI: begin
        state_d = S_REM;
      end
      S_REM: begin
        // Hold until the output register can take the word.
        if (out_free) begin
          out_load = 1'b1;
          k_d      = k_q + CntW'(1);
          state_d  = S_RRD;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_empty = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      best_deg_q  <= '0;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      pass_q      <= '0;
      mask_q      <= '0;
      painted_q   <= '0;
      ordered_q   <= '0;
      success_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      best_deg_q  <= best_deg_d;
      best_idx_q  <= best_idx_d;
      found_q     <= found_d;
      pass_q      <= pass_d;
      mask_q      <= mask_d;
      painted_q   <= painted_d;
      ordered_q   <= ordered_d;
      success_q   <= success_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (out_empty) begin
        out_idx_q  <= '0;
        out_nv_q   <= 1'b0;
        out_col_q  <= '0;
        out_pnt_q  <= 1'b0;
        out_succ_q <= 1'b1;
        out_last_q <= 1'b1;
      end else begin
        out_idx_q  <= gcu_pkg::IDX_W'(ord_rdata);
        out_nv_q   <= 1'b1;
        out_col_q  <= painted_q[ord_rdata] ? gcu_pkg::COL_W'(col_rdata) : '0;
        out_pnt_q  <= painted_q[ord_rdata];
        out_succ_q <= success_q;
        out_last_q <= ((k_q + CntW'(1)) == count_q);
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.node_index = out_idx_q;
  assign out_o.node_valid = out_nv_q;
  assign out_o.colour     = out_col_q;
  assign out_o.painted    = out_pnt_q;
  assign out_o.success    = out_succ_q;
  assign out_o.last       = out_last_q;

  a_painted_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (painted_q & ~ordered_q) == '0)
    else $error("painted node outside the visit order");

  a_mask_painted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q & ~painted_q) == '0)
    else $error("pass mask holds an unpainted node");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NODES))
    else $error("ordered node count beyond node total");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CEV) || (state_q == S_REM) |-> k_q < count_q)
    else $error("visit slot read past the ordered count");

endmodule

FILE: test/greedy_graph_coloring_unit_tb.sv
module greedy_graph_coloring_unit_tb;

  localparam int unsigned NODES   = 32;
  localparam int unsigned COLOURS = 4;

  localparam logic [gcu_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [gcu_pkg::OP_W-1:0]  op;
    logic [gcu_pkg::IDX_W-1:0] node_a;
    logic [gcu_pkg::IDX_W-1:0] node_b;
  } cmd_word_t;

  typedef struct packed {
    logic [gcu_pkg::IDX_W-1:0] node_index;
    logic                      node_valid;
    logic [gcu_pkg::COL_W-1:0] colour;
    logic                      painted;
    logic                      success;
    logic                      last;
  } report_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gcu_in_if  in_if ();
  gcu_out_if out_if ();

  greedy_graph_coloring_unit #(
    .NODES   (NODES),
    .COLOURS (COLOURS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // graph shadow kept in step with accepted commands
  logic [NODES-1:0]          adj_rows  [NODES] = '{default: '0};
  logic [gcu_pkg::DEG_W-1:0] edge_ends [NODES] = '{default: '0};

  cmd_word_t    cmd_q[$];
  report_word_t report_q[$];

  int issued        = 0;
  int edges_loaded  = 0;
  int colourings    = 0;
  int over_budget   = 0;
  int words_checked = 0;
  int failures      = 0;
  bit saw_saturation = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic logic [gcu_pkg::IDX_W-1:0] rnd_node();
    return gcu_pkg::IDX_W'($urandom_range(0, NODES - 1));
  endfunction

  function automatic logic [gcu_pkg::IDX_W-1:0] wrap_node(int v);
    return gcu_pkg::IDX_W'(v % NODES);
  endfunction

  // Welsh-Powell on the shadow graph; queues one report word per ordered node, or one empty word if none
  task automatic colour_graph();
    logic [gcu_pkg::IDX_W-1:0] order [NODES];
    logic [gcu_pkg::COL_W-1:0] hue   [NODES];
    logic [NODES-1:0]          done;
    logic [NODES-1:0]          pass_mask;
    int                        count;
    bit                        all_ok;
    report_word_t              w;
    count  = 0;
    done   = '0;
    all_ok = 1'b1;
    for (int d = gcu_pkg::DEG_MAX; d >= 1; d--) begin
      for (int i = 0; i < NODES; i++) begin
        if (edge_ends[i] == d) begin
          order[count] = gcu_pkg::IDX_W'(i);
          count++;
        end
      end
    end
    for (int c = 0; c < COLOURS; c++) begin
      pass_mask = '0;
      for (int k = 0; k < count; k++) begin
        if (!done[order[k]] && (adj_rows[order[k]] & pass_mask) == '0) begin
          hue[order[k]]       = gcu_pkg::COL_W'(c);
          done[order[k]]      = 1'b1;
          pass_mask[order[k]] = 1'b1;
        end
      end
    end
    for (int k = 0; k < count; k++) begin
      if (!done[order[k]]) all_ok = 1'b0;
    end
    colourings++;
    if (!all_ok) over_budget++;
    if (count == 0) begin
      w = '{node_index: '0, node_valid: 1'b0, colour: '0, painted: 1'b0,
            success: 1'b1, last: 1'b1};
      report_q.insert(report_q.size(), w);
    end else begin
      for (int k = 0; k < count; k++) begin
        w.node_index = order[k];
        w.node_valid = 1'b1;
        w.colour     = done[order[k]] ? hue[order[k]] : '0;
        w.painted    = done[order[k]];
        w.success    = all_ok;
        w.last       = (k == count - 1);
        report_q.insert(report_q.size(), w);
      end
    end
  endtask

  task automatic apply_cmd(input cmd_word_t cmd);
    case (cmd.op)
      gcu_pkg::OP_ADD: begin
        edges_loaded++;
        adj_rows[cmd.node_a][cmd.node_b] = 1'b1;
        adj_rows[cmd.node_b][cmd.node_a] = 1'b1;
        if (edge_ends[cmd.node_a] != gcu_pkg::DEG_MAX) edge_ends[cmd.node_a]++;
        if (edge_ends[cmd.node_b] != gcu_pkg::DEG_MAX) edge_ends[cmd.node_b]++;
        if (edge_ends[cmd.node_a] == gcu_pkg::DEG_MAX) saw_saturation = 1'b1;
      end
      gcu_pkg::OP_RUN: colour_graph();
      gcu_pkg::OP_CLR: begin
        for (int i = 0; i < NODES; i++) begin
          adj_rows[i]  = '0;
          edge_ends[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic [gcu_pkg::OP_W-1:0] op,
                          input logic [gcu_pkg::IDX_W-1:0] a,
                          input logic [gcu_pkg::IDX_W-1:0] b);
    cmd_word_t c;
    c.op     = op;
    c.node_a = a;
    c.node_b = b;
    cmd_q.insert(cmd_q.size(), c);
    issued++;
  endtask

  task automatic gen_sequence();
    int kind;
    int lo;
    int span;
    logic [gcu_pkg::IDX_W-1:0] a;
    logic [gcu_pkg::IDX_W-1:0] b;
    kind = $urandom_range(0, 9);
    lo   = $urandom_range(0, NODES - 1);
    if (kind <= 5) begin
      // edges in a window, then a run; narrow windows give dense graphs
      if ($urandom_range(0, 9) < 7) push_cmd(gcu_pkg::OP_CLR, rnd_node(), rnd_node());
      span = ($urandom_range(0, 3) == 0) ? NODES - 1 : $urandom_range(2, 7);
      repeat ($urandom_range(1, 12)) begin
        a = wrap_node(lo + $urandom_range(0, span));
        b = ($urandom_range(0, 9) == 0) ? a : wrap_node(lo + $urandom_range(0, span));
        push_cmd(gcu_pkg::OP_ADD, a, b);
      end
      push_cmd(gcu_pkg::OP_RUN, rnd_node(), rnd_node());
      if ($urandom_range(0, 3) == 0) push_cmd(gcu_pkg::OP_RUN, rnd_node(), rnd_node());
    end else if (kind <= 7) begin
      // near-clique of 4 to 6 nodes, often beyond the colour budget
      push_cmd(gcu_pkg::OP_CLR, rnd_node(), rnd_node());
      span = $urandom_range(4, 6);
      for (int i = 0; i < span; i++) begin
        for (int j = i + 1; j < span; j++) begin
          if ($urandom_range(0, 7) != 0)
            push_cmd(gcu_pkg::OP_ADD, wrap_node(lo + i), wrap_node(lo + j));
        end
      end
      push_cmd(gcu_pkg::OP_RUN, rnd_node(), rnd_node());
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4))
        push_cmd(gcu_pkg::OP_W'($urandom_range(0, 3)), rnd_node(), rnd_node());
    end else begin
      // graph thrown away right before the run
      repeat ($urandom_range(1, 4)) push_cmd(gcu_pkg::OP_ADD, rnd_node(), rnd_node());
      push_cmd(gcu_pkg::OP_CLR, rnd_node(), rnd_node());
      push_cmd(gcu_pkg::OP_RUN, rnd_node(), rnd_node());
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_word();
    report_word_t got;
    report_word_t want;
    got.node_index = out_if.node_index;
    got.node_valid = out_if.node_valid;
    got.colour     = out_if.colour;
    got.painted    = out_if.painted;
    got.success    = out_if.success;
    got.last       = out_if.last;
    if (report_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("error: unexpected word: idx %0d nv %0b col %0d pnt %0b ok %0b last %0b",
                 got.node_index, got.node_valid, got.colour, got.painted, got.success,
                 got.last);
    end else begin
      want = report_q.pop_front();
      words_checked++;
      if (got.node_index !== want.node_index || got.node_valid !== want.node_valid ||
          got.colour !== want.colour || got.painted !== want.painted ||
          got.success !== want.success || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("error: word %0d expected idx %0d nv %0b col %0d pnt %0b ok %0b last %0b",
                   words_checked, want.node_index, want.node_valid, want.colour,
                   want.painted, want.success, want.last);
          $display("       got      idx %0d nv %0b col %0d pnt %0b ok %0b last %0b",
                   got.node_index, got.node_valid, got.colour, got.painted, got.success,
                   got.last);
        end
      end
    end
  endtask

  // command driver: hold the word until taken, then advance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= gcu_pkg::OP_ADD;
      in_if.node_a    <= '0;
      in_if.node_b    <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_cmd(cmd_q[0]);
        void'(cmd_q.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.operation <= cmd_q[0].op;
          in_if.node_a    <= cmd_q[0].node_a;
          in_if.node_b    <= cmd_q[0].node_b;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_word();
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int budget;
    logic [gcu_pkg::IDX_W-1:0] hub;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = gcu_pkg::OP_ADD;
    in_if.node_a    = '0;
    in_if.node_b    = '0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 7;
    recv_idle_pct   = 64;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty graph, self-loop, duplicate, dropped opcode, repeated run, clear
    push_cmd(gcu_pkg::OP_RUN, 5'd31, 5'd31);
    push_cmd(gcu_pkg::OP_ADD, 5'd0, 5'd31);
    push_cmd(gcu_pkg::OP_ADD, 5'd31, 5'd31);
    push_cmd(gcu_pkg::OP_ADD, 5'd0, 5'd31);
    push_cmd(OP_NONE, 5'd31, 5'd31);
    push_cmd(gcu_pkg::OP_ADD, 5'd5, 5'd10);
    push_cmd(gcu_pkg::OP_RUN, 5'd0, 5'd0);
    push_cmd(gcu_pkg::OP_RUN, 5'd31, 5'd0);
    push_cmd(gcu_pkg::OP_CLR, 5'd31, 5'd31);
    push_cmd(gcu_pkg::OP_RUN, 5'd0, 5'd31);
    // five-clique needs a fifth colour
    for (int i = 1; i <= 5; i++) begin
      for (int j = i + 1; j <= 5; j++)
        push_cmd(gcu_pkg::OP_ADD, gcu_pkg::IDX_W'(i), gcu_pkg::IDX_W'(j));
    end
    push_cmd(gcu_pkg::OP_RUN, 5'd0, 5'd0);
    push_cmd(gcu_pkg::OP_CLR, 5'd0, 5'd0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 7 : 0;
      budget = issued + 35;
      if (ph == 2) begin
        // drive one hub past the degree ceiling
        hub = rnd_node();
        push_cmd(gcu_pkg::OP_CLR, rnd_node(), rnd_node());
        repeat (64) push_cmd(gcu_pkg::OP_ADD, hub, hub);
        repeat (6) push_cmd(gcu_pkg::OP_ADD, hub, rnd_node());
        push_cmd(gcu_pkg::OP_RUN, rnd_node(), rnd_node());
      end
      while (issued < budget) gen_sequence();
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    $display("run covered %0d commands: %0d edge loads, %0d colourings (%0d over budget)",
             issued, edges_loaded, colourings, over_budget);
    $display("%0d report words checked, degree ceiling reached: %0b, %0d mismatches",
             words_checked, saw_saturation, failures);
    if (failures == 0 && report_q.size() == 0) begin
      $display("PASS greedy_graph_coloring_unit");
    end else begin
      $display("FAIL greedy_graph_coloring_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d commands and %0d words outstanding", cmd_q.size(),
             report_q.size());
    $display("FAIL greedy_graph_coloring_unit");
    $finish;
  end

endmodule

FILE: files.f
rtl/gcu_pkg.sv
rtl/gcu_if.sv
rtl/gcu_ram.sv
rtl/gcu_store.sv
rtl/greedy_graph_coloring_unit.sv
test/greedy_graph_coloring_unit_tb.sv
